[src/sccacc_pkg.sv]
// Package for the span collision centroid accumulator.
// Types, widths and opcodes shared by the channel interfaces and modules.
package sccacc_pkg;
	localparam int SLOTS_DEF = 16;
	localparam int SUM_W     = 48;
	localparam int CNT_W     = 16;
	localparam int EMIT_MAX  = 16;

	localparam logic [1:0] OP_ACC   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_FIN   = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic [3:0]         slot_a;
		logic [3:0]         slot_b;
		logic signed [15:0] row_y;
		logic signed [15:0] span_start;
		logic signed [15:0] span_end;
		logic [15:0]        poly_a;
		logic [15:0]        poly_b;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         slot_index;
		logic signed [47:0] centroid_x;
		logic signed [47:0] centroid_y;
		logic [15:0]        coverage;
		logic [15:0]        partner_poly;
		logic               nonempty;
		logic               last;
	} out_item_t;

	// divider control
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

[src/sccacc_in_if.sv]
// Input channel interface: valid/ready plus the span item.
// Depends on sccacc_pkg.
interface sccacc_in_if;
	import sccacc_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/sccacc_out_if.sv]
// Output channel interface: valid/ready plus one slot result.
// Depends on sccacc_pkg.
interface sccacc_out_if;
	import sccacc_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/sccacc_div.sv]
// Restoring divider, one quotient bit per cycle, signed dividend by
// unsigned 16-bit divisor, truncating toward zero. Depends on sccacc_pkg.
module sccacc_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [sccacc_pkg::SUM_W-1:0]     dividend,
	input  logic [sccacc_pkg::CNT_W-1:0]     divisor,
	output logic                             done,
	output logic [sccacc_pkg::SUM_W-1:0]     quotient
);
	import sccacc_pkg::*;
	localparam int BW = $clog2(SUM_W + 1);

	logic [SUM_W-1:0] q_q;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W-1:0] dvs_q;
	logic             neg_q;
	logic [BW-1:0]    cnt_q;
	logic             busy_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;

	assign trial = {rem_q[CNT_W-1:0], q_q[SUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= BW'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == BW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			q_q   <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[CNT_W]) begin
				rem_q <= diff;
				q_q   <= {q_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? (~q_q + 1'b1) : q_q;
endmodule

[src/span_collision_centroid_accumulator.sv]
// Span collision centroid accumulator: not ready while an item is in work. An accumulate
// transfer steps through accept, multiply terms, add into slot a and add into slot b;
// clear is done at accept. Finalize runs every nonempty slot through a shared serial
// divider twice (x then y, each division framed by start and done; an empty slot is
// skipped), then emits min(SLOTS,16) results; valid drops after each accepted result,
// so results are not offered back to back, and an output stall holds the current one.
// Depends on sccacc_pkg, sccacc_in_if, sccacc_out_if and sccacc_div.
module span_collision_centroid_accumulator #(
	parameter int SLOTS = sccacc_pkg::SLOTS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	sccacc_in_if.sink    in_ch,
	sccacc_out_if.source out_ch
);
	import sccacc_pkg::*;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int EMIT = (SLOTS < EMIT_MAX) ? SLOTS : EMIT_MAX;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_UPA  = 7'b0000100,
		ST_UPB  = 7'b0001000,
		ST_DIVX = 7'b0010000,
		ST_DIVY = 7'b0100000,
		ST_EMIT = 7'b1000000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q  [SLOTS];
	logic [SUM_W-1:0] xs_q   [SLOTS];
	logic [SUM_W-1:0] ys_q   [SLOTS];
	logic [15:0]      part_q [SLOTS];

	in_item_t         it_q;
	logic signed [16:0] len_q;
	logic [SUM_W-1:0] dx_q, dy_q;
	logic [SW-1:0]    idx_q;
	logic             div_run_q;
	logic             div_start;
	logic             div_done;
	logic [SUM_W-1:0] div_dvd, div_quo;

	logic signed [16:0] len;
	logic signed [33:0] lx, ly, tri_sum;
	assign len     = 17'(it_q.span_end) - 17'(it_q.span_start);
	assign lx      = 34'(it_q.span_start) * 34'(len);
	assign ly      = 34'(len) * 34'(it_q.row_y);
	assign tri_sum = (34'(len) * (34'(len) + 34'sd1)) >>> 1;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign div_dvd = (state_q == ST_DIVX) ? xs_q[idx_q] : ys_q[idx_q];

	sccacc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(div_dvd), .divisor(cnt_q[idx_q]),
		.done(div_done), .quotient(div_quo)
	);

	logic cur_nz;
	assign cur_nz = (cnt_q[idx_q] != '0);
	assign div_start = (state_q == ST_DIVX || state_q == ST_DIVY) && cur_nz && !div_run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_run_q <= 1'b0;
			idx_q     <= '0;
			out_ch.valid <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				cnt_q[i] <= '0; xs_q[i] <= '0; ys_q[i] <= '0; part_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						it_q <= in_ch.data;
						case (in_ch.data.op)
							OP_ACC:   state_q <= ST_MUL;
							OP_CLEAR: begin
								for (int i = 0; i < SLOTS; i++) begin
									cnt_q[i] <= '0; xs_q[i] <= '0;
									ys_q[i] <= '0; part_q[i] <= '0;
								end
							end
							OP_FIN: begin
								idx_q   <= '0;
								state_q <= ST_DIVX;
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					len_q   <= len;
					dx_q    <= SUM_W'(lx + tri_sum);
					dy_q    <= SUM_W'(ly);
					state_q <= ST_UPA;
				end
				ST_UPA: begin
					if (32'(it_q.slot_a) < SLOTS) begin
						cnt_q[SW'(it_q.slot_a)]  <= cnt_q[SW'(it_q.slot_a)] + len_q[15:0];
						xs_q[SW'(it_q.slot_a)]   <= xs_q[SW'(it_q.slot_a)] + dx_q;
						ys_q[SW'(it_q.slot_a)]   <= ys_q[SW'(it_q.slot_a)] + dy_q;
						part_q[SW'(it_q.slot_a)] <= it_q.poly_b;
					end
					state_q <= ST_UPB;
				end
				ST_UPB: begin
					if (32'(it_q.slot_b) < SLOTS) begin
						cnt_q[SW'(it_q.slot_b)]  <= cnt_q[SW'(it_q.slot_b)] + len_q[15:0];
						xs_q[SW'(it_q.slot_b)]   <= xs_q[SW'(it_q.slot_b)] + dx_q;
						ys_q[SW'(it_q.slot_b)]   <= ys_q[SW'(it_q.slot_b)] + dy_q;
						part_q[SW'(it_q.slot_b)] <= it_q.poly_a;
					end
					state_q <= ST_IDLE;
				end
				ST_DIVX, ST_DIVY: begin
					if (!cur_nz) begin
						if (idx_q == SW'(SLOTS - 1)) begin
							idx_q <= '0; state_q <= ST_EMIT;
						end else begin
							idx_q <= idx_q + 1'b1; state_q <= ST_DIVX;
						end
					end else if (div_start) begin
						div_run_q <= 1'b1;
					end else if (div_done) begin
						div_run_q <= 1'b0;
						if (state_q == ST_DIVX) begin
							xs_q[idx_q] <= div_quo;
							state_q <= ST_DIVY;
						end else begin
							ys_q[idx_q] <= div_quo;
							if (idx_q == SW'(SLOTS - 1)) begin
								idx_q <= '0; state_q <= ST_EMIT;
							end else begin
								idx_q <= idx_q + 1'b1; state_q <= ST_DIVX;
							end
						end
					end
				end
				ST_EMIT: begin
					if (!out_ch.valid) begin
						out_ch.valid <= 1'b1;
					end else if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						if (idx_q == SW'(EMIT - 1)) begin
							state_q <= ST_IDLE;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// emit fields read straight from the record selected by idx_q
	assign out_ch.data.slot_index   = 4'(idx_q);
	assign out_ch.data.centroid_x   = xs_q[idx_q];
	assign out_ch.data.centroid_y   = ys_q[idx_q];
	assign out_ch.data.coverage     = cnt_q[idx_q];
	assign out_ch.data.partner_poly = part_q[idx_q];
	assign out_ch.data.nonempty     = cur_nz;
	assign out_ch.data.last         = (idx_q == SW'(EMIT - 1));
endmodule

[src/sccacc_checker.sv]
// Port-level checker for the span collision centroid accumulator.
// Depends on sccacc_pkg; bound to the top level below.
module sccacc_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input sccacc_pkg::out_item_t out_data
);
	import sccacc_pkg::*;
	// no new input while results are pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready during emission");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	a_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.nonempty == (out_data.coverage != '0)))
		else $error("nonempty flag mismatch");
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last |=> !out_valid)
		else $error("result after last");
endmodule

bind span_collision_centroid_accumulator sccacc_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
